// ----- hw/rtl/wkc_pkg.sv -----
// wkc_pkg: constants, types and base folding for the weighted k-mer counter
// used by weighted_kmer_counter_core; no dependencies
`timescale 1ns / 1ps

package wkc_pkg;

   // longest k-mer the table is sized for
   localparam int MAX_KMER    = 8;
   localparam int CODE_BITS   = 2 * MAX_KMER;
   localparam int TABLE_DEPTH = 1 << CODE_BITS;
   localparam int RUN_BITS    = $clog2(MAX_KMER + 1);
   localparam int COUNT_BITS  = 32;
   localparam int WEIGHT_BITS = 16;
   localparam int FIELD_BITS  = 16;
   localparam int KSIZE_BITS  = 4;
   localparam logic [KSIZE_BITS-1:0] KSIZE_RESET = KSIZE_BITS'(8);

   // command codes
   typedef enum logic {
      CMD_COUNT = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef logic [CODE_BITS-1:0]  code_type;
   typedef logic [RUN_BITS-1:0]   run_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   // folded base: valid flag and two-bit code
   typedef struct packed {
      logic       ok;
      logic [1:0] code;
   } base_type;

   // fold upper and lower case ACGT to A=0 C=1 G=2 T=3
   function automatic base_type fold_base(input logic [7:0] ch);
      base_type b;
      b.ok   = 1'b1;
      b.code = 2'd0;
      case (ch) inside
         8'h41, 8'h61: b.code = 2'd0;
         8'h43, 8'h63: b.code = 2'd1;
         8'h47, 8'h67: b.code = 2'd2;
         8'h54, 8'h74: b.code = 2'd3;
         default: b.ok = 1'b0;
      endcase
      return b;
   endfunction

endpackage

// ----- hw/rtl/wkc_ram.sv -----
// wkc_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module wkc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/weighted_kmer_counter_core.sv -----
// weighted_kmer_counter_core: k-mer window, count table pipeline and reset clear
// depends on wkc_pkg and wkc_ram
`timescale 1ns / 1ps

// Usage
//   Request channel: drive req_* and raise start; the beat is taken on a
//   rising edge with start high and busy low. req_command selects counting
//   one base or reading the count at req_query_code.
//   Response channel: rsp_valid strobes for one cycle with rsp_kmer_code and
//   rsp_kmer_count. A base that is not ACGT, or a read still shorter than the
//   k-mer size, gives no response.
//   Config channel: csr_kmer_size is written when csr_valid and csr_ready are
//   high; csr_ready is always high. Write it only while no request is in flight.
// Timing
//   A response appears the cycle after its request is taken. One request is
//   taken every cycle while busy is low; the table read, saturating add and
//   write back overlap with the next beat, and a write that lands on the
//   entry just read is forwarded from a bypass register.
// Reset
//   After reset the count table is swept to zero, one entry a cycle, over
//   all 65536 (4^MAX_KMER) entries; busy stays high during the sweep.
//   The receiver cannot stall, so no response ever waits.
module weighted_kmer_counter_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [7:0]  req_base_char,
   input  logic        req_read_start,
   input  logic [15:0] req_read_weight,
   input  logic [15:0] req_query_code,
   // response channel
   output logic        rsp_valid,
   output logic [15:0] rsp_kmer_code,
   output logic [31:0] rsp_kmer_count,
   // config channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_kmer_size
);

   // state
   logic                  clearing_ff, clearing_in;
   wkc_pkg::code_type     clear_addr_ff, clear_addr_in;
   logic [wkc_pkg::KSIZE_BITS-1:0] kmer_size_ff, kmer_size_in;
   wkc_pkg::code_type     window_ff, window_in;
   wkc_pkg::run_type      run_ff, run_in;

   // pipeline stage after the ram read
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_count_ff, s1_count_in;
   wkc_pkg::code_type     s1_addr_ff, s1_addr_in;
   logic [wkc_pkg::WEIGHT_BITS-1:0] s1_weight_ff, s1_weight_in;

   // bypass of the last write
   logic                  fwd_valid_ff, fwd_valid_in;
   wkc_pkg::code_type     fwd_addr_ff, fwd_addr_in;
   wkc_pkg::count_type    fwd_data_ff, fwd_data_in;

   logic                  accept;
   wkc_pkg::base_type     base;
   wkc_pkg::run_type      k_eff;
   wkc_pkg::code_type     win_base, run_mask, kmer_code, query_code, rd_addr;
   wkc_pkg::run_type      run_base;
   logic [31:0]           query_wide;
   logic                  emit;
   wkc_pkg::count_type    ram_rdata, old_count, new_count;
   logic [wkc_pkg::COUNT_BITS:0] sum;
   logic                  wr_en;
   wkc_pkg::code_type     wr_addr;
   wkc_pkg::count_type    wr_data;
   logic [31:0]           code_wide;

   assign busy      = clearing_ff;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // effective k-mer size, clamped to 1..MAX_KMER
   always_comb begin
      if (kmer_size_ff == '0) begin
         k_eff = wkc_pkg::RUN_BITS'(1);
      end else if (kmer_size_ff > wkc_pkg::KSIZE_BITS'(wkc_pkg::MAX_KMER)) begin
         k_eff = wkc_pkg::RUN_BITS'(wkc_pkg::MAX_KMER);
      end else begin
         k_eff = kmer_size_ff[wkc_pkg::RUN_BITS-1:0];
      end
   end

   // window and run update for a count beat
   always_comb begin
      base       = wkc_pkg::fold_base(req_base_char);
      win_base   = req_read_start ? '0 : window_ff;
      run_base   = req_read_start ? '0 : run_ff;
      window_in  = window_ff;
      run_in     = run_ff;
      if (accept && wkc_pkg::cmd_type'(req_command) == wkc_pkg::CMD_COUNT) begin
         if (base.ok) begin
            window_in = {win_base[wkc_pkg::CODE_BITS-3:0], base.code};
            run_in    = (run_base < wkc_pkg::RUN_BITS'(wkc_pkg::MAX_KMER)) ?
                        run_base + wkc_pkg::RUN_BITS'(1) : run_base;
         end else begin
            window_in = win_base;
            run_in    = '0;
         end
      end
   end

   // table address for this beat
   always_comb begin
      run_mask   = ~({wkc_pkg::CODE_BITS{1'b1}} << {k_eff, 1'b0});
      kmer_code  = window_in & run_mask;
      query_wide = {16'b0, req_query_code};
      query_code = query_wide[wkc_pkg::CODE_BITS-1:0];
      if (wkc_pkg::cmd_type'(req_command) == wkc_pkg::CMD_QUERY) begin
         rd_addr = query_code;
         emit    = accept;
      end else begin
         rd_addr = kmer_code;
         emit    = accept && base.ok && (run_in >= k_eff);
      end
   end

   // stage one capture
   always_comb begin
      s1_valid_in  = emit;
      s1_count_in  = wkc_pkg::cmd_type'(req_command) == wkc_pkg::CMD_COUNT;
      s1_addr_in   = rd_addr;
      s1_weight_in = req_read_weight;
   end

   // read data with bypass, saturating add
   always_comb begin
      old_count = (fwd_valid_ff && fwd_addr_ff == s1_addr_ff) ? fwd_data_ff : ram_rdata;
      sum       = {1'b0, old_count} + {17'b0, s1_weight_ff};
      new_count = sum[wkc_pkg::COUNT_BITS] ? '1 : sum[wkc_pkg::COUNT_BITS-1:0];
   end

   // ram write port: reset sweep or count write back
   always_comb begin
      if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_addr = clear_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = s1_valid_ff && s1_count_ff;
         wr_addr = s1_addr_ff;
         wr_data = new_count;
      end
      fwd_valid_in = s1_valid_ff && s1_count_ff && !clearing_ff;
      fwd_addr_in  = s1_addr_ff;
      fwd_data_in  = new_count;
   end

   // reset sweep counter
   always_comb begin
      clear_addr_in = clear_addr_ff;
      clearing_in   = clearing_ff;
      if (clearing_ff) begin
         clear_addr_in = clear_addr_ff + wkc_pkg::CODE_BITS'(1);
         if (clear_addr_ff == '1) begin
            clearing_in = 1'b0;
         end
      end
   end

   // config register
   always_comb begin
      kmer_size_in = (csr_valid && csr_ready) ? csr_kmer_size : kmer_size_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         kmer_size_ff  <= wkc_pkg::KSIZE_RESET;
         window_ff     <= '0;
         run_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
         kmer_size_ff  <= kmer_size_in;
         window_ff     <= window_in;
         run_ff        <= run_in;
         s1_valid_ff   <= s1_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_count_ff  <= s1_count_in;
      s1_addr_ff   <= s1_addr_in;
      s1_weight_ff <= s1_weight_in;
      fwd_addr_ff  <= fwd_addr_in;
      fwd_data_ff  <= fwd_data_in;
   end

   // count table
   wkc_ram #(
      .WIDTH(wkc_pkg::COUNT_BITS),
      .DEPTH(wkc_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // response beat
   assign code_wide      = 32'(s1_addr_ff);
   assign rsp_valid      = s1_valid_ff;
   assign rsp_kmer_code  = code_wide[wkc_pkg::FIELD_BITS-1:0];
   assign rsp_kmer_count = s1_count_ff ? new_count : old_count;

`ifndef SYNTHESIS
   // no beat is in the pipeline while the table is being swept
   a_no_beat_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !s1_valid_ff)
      else $error("response pending during table sweep");

   // every response comes from a beat taken the cycle before
   a_rsp_from_accept: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $past(start && !busy))
      else $error("response without a taken request");

   // bypass holds only the write back of a count beat
   a_fwd_from_write: assert property (@(posedge clock) disable iff (reset)
      fwd_valid_ff |-> $past(s1_valid_ff && s1_count_ff))
      else $error("bypass loaded without a write back");

   // a count write back never lowers the entry
   a_count_monotone: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_count_ff && !clearing_ff) |-> (new_count >= old_count))
      else $error("count decreased on write back");
`endif

endmodule
